/* sv/triangle_unit_normal_macros.svh */
// ----------------------------------------------------------------------------
// triangle_unit_normal_macros
// assertion macros shared by the triangle unit normal rtl
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_UNIT_NORMAL_MACROS_SVH
`define TRIANGLE_UNIT_NORMAL_MACROS_SVH

`ifndef ASSERT_OFF

`define TUN_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

`define TUN_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define TUN_ASSERT_IMPLIES(lbl, ante, cons)

`define TUN_ASSERT_NEVER(lbl, cond)

`endif

`endif

/* sv/tun_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_pkg
// widths and payload types of the triangle unit normal pipeline
// ----------------------------------------------------------------------------
package tun_pkg;

    localparam int COORD_W  = 16;
    localparam int FRAC_W   = 14;
    localparam int OUT_W    = FRAC_W + 2;
    localparam int EDGE_W   = COORD_W + 1;
    localparam int PROD_W   = 2 * EDGE_W;
    localparam int CROSS_W  = PROD_W + 1;
    localparam int MAG_W    = 2 * COORD_W + 2;
    localparam int POS_W    = $clog2(MAG_W);
    localparam int NORM_W   = 30;
    localparam int ROOT_W   = NORM_W + 1;
    localparam int SQ_W     = 2 * ROOT_W;
    localparam int REM_W    = ROOT_W + 3;
    localparam int QUO_W    = FRAC_W + 1;
    localparam int NUM_W    = NORM_W + FRAC_W + 1;

    localparam logic signed [OUT_W-1:0] NORM_ONE = {2'b01, {FRAC_W{1'b0}}};
    localparam logic signed [OUT_W-1:0] NORM_NEG = {2'b11, {FRAC_W{1'b0}}};

    typedef struct packed {
        logic signed [COORD_W-1:0] v0_x;
        logic signed [COORD_W-1:0] v0_y;
        logic signed [COORD_W-1:0] v0_z;
        logic signed [COORD_W-1:0] v1_x;
        logic signed [COORD_W-1:0] v1_y;
        logic signed [COORD_W-1:0] v1_z;
        logic signed [COORD_W-1:0] v2_x;
        logic signed [COORD_W-1:0] v2_y;
        logic signed [COORD_W-1:0] v2_z;
    } triangle_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] normal_x;
        logic signed [OUT_W-1:0] normal_y;
        logic signed [OUT_W-1:0] normal_z;
        logic                    degenerate;
    } normal_t;

    typedef struct packed {
        logic [2:0] neg;
        logic       degenerate;
    } side_t;

    typedef struct packed {
        logic [2:0][NORM_W-1:0] a;
        side_t                  side;
    } lane_t;

endpackage

/* sv/tun_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_sqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
module tun_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [tun_pkg::SQ_W-1:0]    in_s,
    input  tun_pkg::lane_t              in_lane,
    output logic                        out_valid,
    output logic [tun_pkg::ROOT_W-1:0]  out_root,
    output tun_pkg::lane_t              out_lane
);

    localparam int N      = tun_pkg::ROOT_W;
    localparam int REM_W  = tun_pkg::REM_W;
    localparam int ROOT_W = tun_pkg::ROOT_W;
    localparam int SQ_W   = tun_pkg::SQ_W;

    logic                 vld_reg  [N];
    logic [REM_W-1:0]     rem_reg  [N];
    logic [ROOT_W-1:0]    root_reg [N];
    logic [SQ_W-1:0]      s_reg    [N];
    tun_pkg::lane_t       lane_reg [N];

    for (genvar i = 0; i < N; i++)
    begin : g_step
        logic               vld_prev;
        logic [REM_W-1:0]   rem_prev;
        logic [ROOT_W-1:0]  root_prev;
        logic [SQ_W-1:0]    s_prev;
        tun_pkg::lane_t     lane_prev;
        logic [REM_W-1:0]   rem_sh;
        logic [REM_W-1:0]   trial;
        logic               fits;

        if (i == 0)
        begin : g_first
            assign vld_prev  = in_valid;
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign s_prev    = in_s;
            assign lane_prev = in_lane;
        end
        else
        begin : g_next
            assign vld_prev  = vld_reg[i-1];
            assign rem_prev  = rem_reg[i-1];
            assign root_prev = root_reg[i-1];
            assign s_prev    = s_reg[i-1];
            assign lane_prev = lane_reg[i-1];
        end

        // bring down the next pair of radicand bits
        assign rem_sh = {rem_prev[REM_W-3:0], s_prev[SQ_W-1 -: 2]};
        assign trial  = REM_W'({root_prev, 2'b01});
        assign fits   = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= fits ? (rem_sh - trial) : rem_sh;
                root_reg[i] <= {root_prev[ROOT_W-2:0], fits};
                s_reg[i]    <= s_prev << 2;
                lane_reg[i] <= lane_prev;
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_root  = root_reg[N-1];
    assign out_lane  = lane_reg[N-1];

endmodule

/* sv/tun_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tun_div
// three-lane pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module tun_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [2:0][tun_pkg::NUM_W-1:0]      in_num,
    input  logic [tun_pkg::ROOT_W-1:0]          in_den,
    input  tun_pkg::side_t                      in_side,
    output logic                                out_valid,
    output logic [2:0][tun_pkg::QUO_W-1:0]      out_q,
    output tun_pkg::side_t                      out_side
);

    localparam int N      = tun_pkg::QUO_W;
    localparam int QUO_W  = tun_pkg::QUO_W;
    localparam int ROOT_W = tun_pkg::ROOT_W;
    localparam int NUM_W  = tun_pkg::NUM_W;

    logic                          vld_reg  [N];
    logic [2:0][ROOT_W-1:0]        rem_reg  [N];
    logic [2:0][QUO_W-1:0]         bits_reg [N];
    logic [2:0][QUO_W-1:0]         q_reg    [N];
    logic [ROOT_W-1:0]             den_reg  [N];
    tun_pkg::side_t                side_reg [N];

    for (genvar i = 0; i < N; i++)
    begin : g_step
        logic                    vld_prev;
        logic [2:0][ROOT_W-1:0]  rem_prev;
        logic [2:0][QUO_W-1:0]   bits_prev;
        logic [2:0][QUO_W-1:0]   q_prev;
        logic [ROOT_W-1:0]       den_prev;
        tun_pkg::side_t          side_prev;
        logic [2:0][ROOT_W-1:0]  rem_next;
        logic [2:0][QUO_W-1:0]   q_next;

        if (i == 0)
        begin : g_first
            assign vld_prev  = in_valid;
            assign den_prev  = in_den;
            assign side_prev = in_side;
            assign q_prev    = '0;
            for (genvar j = 0; j < 3; j++)
            begin : g_lane
                assign rem_prev[j]  = ROOT_W'(in_num[j][NUM_W-1:QUO_W]);
                assign bits_prev[j] = in_num[j][QUO_W-1:0];
            end
        end
        else
        begin : g_next
            assign vld_prev  = vld_reg[i-1];
            assign rem_prev  = rem_reg[i-1];
            assign bits_prev = bits_reg[i-1];
            assign q_prev    = q_reg[i-1];
            assign den_prev  = den_reg[i-1];
            assign side_prev = side_reg[i-1];
        end

        always_comb
        begin
            logic [ROOT_W:0] rem_sh;
            logic            fits;
            for (int j = 0; j < 3; j++)
            begin
                rem_sh      = {rem_prev[j], bits_prev[j][QUO_W-1]};
                fits        = (rem_sh >= {1'b0, den_prev});
                rem_next[j] = fits ? ROOT_W'(rem_sh - {1'b0, den_prev})
                                   : rem_sh[ROOT_W-1:0];
                q_next[j]   = {q_prev[j][QUO_W-2:0], fits};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= rem_next;
                q_reg[i]    <= q_next;
                den_reg[i]  <= den_prev;
                side_reg[i] <= side_prev;
                for (int j = 0; j < 3; j++)
                begin
                    bits_reg[i][j] <= bits_prev[j] << 1;
                end
            end
        end
    end

    assign out_valid = vld_reg[N-1];
    assign out_q     = q_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

/* sv/triangle_unit_normal.sv */
// 56 register stages lie between the input transfer and normal_valid
// throughput: one triangle per cycle unless stalled; 31-stage root, 15-stage divider pipelined
// a stalled output freezes the whole pipeline, nothing is lost or repeated
// reset (rst_n low, asynchronous) clears every valid bit, no item survives it
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_unit_normal
// cross product of two triangle edges scaled to unit length in Q1.14
// ----------------------------------------------------------------------------
`include "triangle_unit_normal_macros.svh"

module triangle_unit_normal (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                triangle_valid,
    output logic                triangle_ready,
    input  tun_pkg::triangle_t  triangle,
    output logic                normal_valid,
    input  logic                normal_ready,
    output tun_pkg::normal_t    normal
);

    localparam int EDGE_W  = tun_pkg::EDGE_W;
    localparam int PROD_W  = tun_pkg::PROD_W;
    localparam int CROSS_W = tun_pkg::CROSS_W;
    localparam int MAG_W   = tun_pkg::MAG_W;
    localparam int POS_W   = tun_pkg::POS_W;
    localparam int NORM_W  = tun_pkg::NORM_W;
    localparam int ROOT_W  = tun_pkg::ROOT_W;
    localparam int SQ_W    = tun_pkg::SQ_W;
    localparam int NUM_W   = tun_pkg::NUM_W;
    localparam int QUO_W   = tun_pkg::QUO_W;
    localparam int OUT_W   = tun_pkg::OUT_W;
    localparam int FRAC_W  = tun_pkg::FRAC_W;
    localparam int TOP     = NORM_W - 1;

    logic                       en;
    logic [9:1]                 vld_reg;

    logic signed [EDGE_W-1:0]   e0_reg [3];
    logic signed [EDGE_W-1:0]   e1_reg [3];
    logic signed [PROD_W-1:0]   p_reg  [6];
    logic [2:0][MAG_W-1:0]      mag3_reg;
    logic [2:0]                 neg3_reg;
    logic [2:0][MAG_W-1:0]      mag4_reg;
    logic [MAG_W-1:0]           m4_reg;
    tun_pkg::side_t             side4_reg;
    logic [2:0][MAG_W-1:0]      mag5_reg;
    logic [POS_W-1:0]           pos5_reg;
    tun_pkg::side_t             side5_reg;
    tun_pkg::lane_t             lane6_reg;
    logic [2:0][2*NORM_W-1:0]   sq7_reg;
    tun_pkg::lane_t             lane7_reg;
    logic [SQ_W-1:0]            s8_reg;
    tun_pkg::lane_t             lane8_reg;
    logic [2:0][NUM_W-1:0]      num9_reg;
    logic [ROOT_W-1:0]          den9_reg;
    tun_pkg::side_t             side9_reg;
    logic                       out_vld_reg;
    tun_pkg::normal_t           normal_reg;

    logic [2:0][MAG_W-1:0]      mag3_next;
    logic [2:0]                 neg3_next;
    logic [MAG_W-1:0]           m4_next;
    logic [POS_W-1:0]           pos5_next;
    logic [2:0][NORM_W-1:0]     a6_next;
    tun_pkg::normal_t           normal_next;

    logic                       sq_vld;
    logic [ROOT_W-1:0]          sq_root;
    tun_pkg::lane_t             sq_lane;
    logic                       dv_vld;
    logic [2:0][QUO_W-1:0]      dv_q;
    tun_pkg::side_t             dv_side;

    assign en             = !out_vld_reg || normal_ready;
    assign triangle_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {sq_vld, vld_reg[7:1], triangle_valid};
            out_vld_reg <= dv_vld;
        end
    end

    // cross product terms and magnitudes
    always_comb
    begin
        logic signed [CROSS_W-1:0] c [3];
        c[0] = CROSS_W'(p_reg[0]) - CROSS_W'(p_reg[1]);
        c[1] = CROSS_W'(p_reg[2]) - CROSS_W'(p_reg[3]);
        c[2] = CROSS_W'(p_reg[4]) - CROSS_W'(p_reg[5]);
        for (int j = 0; j < 3; j++)
        begin
            neg3_next[j] = c[j][CROSS_W-1];
            mag3_next[j] = c[j][CROSS_W-1] ? MAG_W'(-c[j]) : MAG_W'(c[j]);
        end
    end

    always_comb
    begin
        m4_next = mag3_reg[0];
        if (mag3_reg[1] > m4_next)
        begin
            m4_next = mag3_reg[1];
        end
        if (mag3_reg[2] > m4_next)
        begin
            m4_next = mag3_reg[2];
        end
    end

    // leading one position of the largest magnitude
    always_comb
    begin
        pos5_next = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (m4_reg[i])
            begin
                pos5_next = POS_W'(i);
            end
        end
    end

    // common shift that puts the largest magnitude in [2^29, 2^30)
    always_comb
    begin
        logic [POS_W-1:0] lsh;
        logic [POS_W-1:0] rsh;
        lsh = POS_W'(TOP) - pos5_reg;
        rsh = pos5_reg - POS_W'(TOP);
        for (int j = 0; j < 3; j++)
        begin
            if (pos5_reg <= POS_W'(TOP))
            begin
                a6_next[j] = NORM_W'(mag5_reg[j] << lsh);
            end
            else
            begin
                a6_next[j] = NORM_W'(mag5_reg[j] >> rsh);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e0_reg[0] <= EDGE_W'(triangle.v1_x) - EDGE_W'(triangle.v0_x);
            e0_reg[1] <= EDGE_W'(triangle.v1_y) - EDGE_W'(triangle.v0_y);
            e0_reg[2] <= EDGE_W'(triangle.v1_z) - EDGE_W'(triangle.v0_z);
            e1_reg[0] <= EDGE_W'(triangle.v2_x) - EDGE_W'(triangle.v1_x);
            e1_reg[1] <= EDGE_W'(triangle.v2_y) - EDGE_W'(triangle.v1_y);
            e1_reg[2] <= EDGE_W'(triangle.v2_z) - EDGE_W'(triangle.v1_z);

            p_reg[0] <= e0_reg[1] * e1_reg[2];
            p_reg[1] <= e0_reg[2] * e1_reg[1];
            p_reg[2] <= e0_reg[2] * e1_reg[0];
            p_reg[3] <= e0_reg[0] * e1_reg[2];
            p_reg[4] <= e0_reg[0] * e1_reg[1];
            p_reg[5] <= e0_reg[1] * e1_reg[0];

            mag3_reg <= mag3_next;
            neg3_reg <= neg3_next;

            mag4_reg             <= mag3_reg;
            m4_reg               <= m4_next;
            side4_reg.neg        <= neg3_reg;
            side4_reg.degenerate <= (m4_next == '0);

            mag5_reg  <= mag4_reg;
            pos5_reg  <= pos5_next;
            side5_reg <= side4_reg;

            lane6_reg.a    <= a6_next;
            lane6_reg.side <= side5_reg;

            for (int j = 0; j < 3; j++)
            begin
                sq7_reg[j] <= lane6_reg.a[j] * lane6_reg.a[j];
            end
            lane7_reg <= lane6_reg;

            s8_reg    <= SQ_W'(sq7_reg[0]) + SQ_W'(sq7_reg[1]) + SQ_W'(sq7_reg[2]);
            lane8_reg <= lane7_reg;

            for (int j = 0; j < 3; j++)
            begin
                num9_reg[j] <= (NUM_W'(sq_lane.a[j]) << FRAC_W)
                               + NUM_W'(sq_root >> 1);
            end
            den9_reg  <= sq_root;
            side9_reg <= sq_lane.side;

            normal_reg <= normal_next;
        end
    end

    tun_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld_reg[8]),
        .in_s      (s8_reg),
        .in_lane   (lane8_reg),
        .out_valid (sq_vld),
        .out_root  (sq_root),
        .out_lane  (sq_lane)
    );

    tun_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (vld_reg[9]),
        .in_num    (num9_reg),
        .in_den    (den9_reg),
        .in_side   (side9_reg),
        .out_valid (dv_vld),
        .out_q     (dv_q),
        .out_side  (dv_side)
    );

    // sign restore, degenerate triangles give a zero vector
    always_comb
    begin
        logic [OUT_W-1:0] comp [3];
        for (int j = 0; j < 3; j++)
        begin
            comp[j] = dv_side.neg[j] ? (OUT_W'(0) - OUT_W'(dv_q[j])) : OUT_W'(dv_q[j]);
        end
        normal_next.degenerate = dv_side.degenerate;
        normal_next.normal_x   = dv_side.degenerate ? '0 : $signed(comp[0]);
        normal_next.normal_y   = dv_side.degenerate ? '0 : $signed(comp[1]);
        normal_next.normal_z   = dv_side.degenerate ? '0 : $signed(comp[2]);
    end

    assign normal_valid = out_vld_reg;
    assign normal       = normal_reg;

    `TUN_ASSERT_IMPLIES(a_degenerate_zero, normal_valid && normal.degenerate,
        normal.normal_x == '0 && normal.normal_y == '0 && normal.normal_z == '0)
    `TUN_ASSERT_IMPLIES(a_unit_range, normal_valid && !normal.degenerate,
        normal.normal_x <= tun_pkg::NORM_ONE && normal.normal_x >= tun_pkg::NORM_NEG &&
        normal.normal_y <= tun_pkg::NORM_ONE && normal.normal_y >= tun_pkg::NORM_NEG &&
        normal.normal_z <= tun_pkg::NORM_ONE && normal.normal_z >= tun_pkg::NORM_NEG)
    `TUN_ASSERT_NEVER(a_root_scaled,
        sq_vld && !sq_lane.side.degenerate && sq_root[ROOT_W-1:NORM_W-1] == '0)

endmodule

/* sim/triangle_unit_normal_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_unit_normal_tb
// drives triangles through the unit normal pipeline with random idling on
// both channels and checks each normal against a fixed-point predictor
// ----------------------------------------------------------------------------
module triangle_unit_normal_tb;

    logic               clk;
    logic               rst_n;
    logic               triangle_valid;
    logic               triangle_ready;
    tun_pkg::triangle_t triangle;
    logic               normal_valid;
    logic               normal_ready;
    tun_pkg::normal_t   normal;

    tun_pkg::normal_t   normal_queue[$];
    int                 error_count;
    int                 result_count;
    int                 stall_left;
    bit                 idle_enable;

    triangle_unit_normal uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .triangle_valid (triangle_valid),
        .triangle_ready (triangle_ready),
        .triangle       (triangle),
        .normal_valid   (normal_valid),
        .normal_ready   (normal_ready),
        .normal         (normal)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [63:0] floor_root(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic tun_pkg::normal_t unit_normal(tun_pkg::triangle_t t);
        logic signed [63:0] v[9];
        logic signed [63:0] e0[3];
        logic signed [63:0] e1[3];
        logic signed [63:0] c[3];
        logic [63:0] a[3];
        logic [63:0] q[3];
        logic [63:0] m;
        logic [63:0] len;
        logic [tun_pkg::OUT_W-1:0] comp[3];
        tun_pkg::normal_t n;
        v[0] = t.v0_x; v[1] = t.v0_y; v[2] = t.v0_z;
        v[3] = t.v1_x; v[4] = t.v1_y; v[5] = t.v1_z;
        v[6] = t.v2_x; v[7] = t.v2_y; v[8] = t.v2_z;
        for (int i = 0; i < 3; i++)
        begin
            e0[i] = v[3+i] - v[i];
            e1[i] = v[6+i] - v[3+i];
        end
        c[0] = e0[1] * e1[2] - e0[2] * e1[1];
        c[1] = e0[2] * e1[0] - e0[0] * e1[2];
        c[2] = e0[0] * e1[1] - e0[1] * e1[0];
        m = 0;
        for (int i = 0; i < 3; i++)
        begin
            a[i] = c[i] < 0 ? -c[i] : c[i];
            if (a[i] > m)
                m = a[i];
        end
        n = '0;
        if (m == 0)
        begin
            n.degenerate = 1'b1;
            return n;
        end
        while (m < (64'd1 << 29))
        begin
            m = m << 1;
            for (int i = 0; i < 3; i++)
                a[i] = a[i] << 1;
        end
        while (m >= (64'd1 << 30))
        begin
            m = m >> 1;
            for (int i = 0; i < 3; i++)
                a[i] = a[i] >> 1;
        end
        len = floor_root(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
        for (int i = 0; i < 3; i++)
        begin
            q[i] = ((a[i] << tun_pkg::FRAC_W) + (len >> 1)) / len;
            if (q[i] > (64'd1 << tun_pkg::FRAC_W))
                q[i] = 64'd1 << tun_pkg::FRAC_W;
            comp[i] = c[i] < 0 ? -q[i][tun_pkg::OUT_W-1:0] : q[i][tun_pkg::OUT_W-1:0];
        end
        n.normal_x = comp[0];
        n.normal_y = comp[1];
        n.normal_z = comp[2];
        return n;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    task automatic send_triangle(tun_pkg::triangle_t t);
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            triangle_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        triangle_valid <= 1'b1;
        triangle <= t;
        @(posedge clk);
        while (!triangle_ready)
            @(posedge clk);
        normal_queue = {normal_queue, unit_normal(t)};
    endtask

    // receiver side: random stalls, check on each transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (normal_valid && normal_ready)
            begin
                if (normal_queue.size() == 0)
                begin
                    $display("unexpected normal transfer");
                    error_count++;
                end
                else
                begin
                    tun_pkg::normal_t w;
                    w = normal_queue.pop_front();
                    if (normal.normal_x !== w.normal_x)
                        report_mismatch("normal_x", normal.normal_x, w.normal_x);
                    if (normal.normal_y !== w.normal_y)
                        report_mismatch("normal_y", normal.normal_y, w.normal_y);
                    if (normal.normal_z !== w.normal_z)
                        report_mismatch("normal_z", normal.normal_z, w.normal_z);
                    if (normal.degenerate !== w.degenerate)
                        report_mismatch("degenerate", normal.degenerate, w.degenerate);
                end
                result_count++;
            end
            if (stall_left > 0)
            begin
                normal_ready <= 1'b0;
                stall_left--;
            end
            else if (idle_enable && $urandom_range(0, 5) == 0)
            begin
                normal_ready <= 1'b0;
                stall_left = $urandom_range(0, 4);
            end
            else
                normal_ready <= 1'b1;
        end
    end

    function automatic tun_pkg::triangle_t random_triangle();
        tun_pkg::triangle_t t;
        logic [15:0] base;
        t = ($bits(tun_pkg::triangle_t))'({$urandom, $urandom, $urandom, $urandom, $urandom});
        // small triangles near a random base point in x and y, with small z
        if ($urandom_range(0, 1) == 0)
        begin
            base = 16'($urandom);
            t.v0_x = base + 16'($urandom_range(0, 63));
            t.v1_x = base + 16'($urandom_range(0, 63));
            t.v2_x = base + 16'($urandom_range(0, 63));
            t.v0_y = base - 16'($urandom_range(0, 63));
            t.v1_y = base - 16'($urandom_range(0, 63));
            t.v2_y = base - 16'($urandom_range(0, 63));
            t.v0_z = 16'($urandom_range(0, 15));
            t.v1_z = 16'($urandom_range(0, 15));
            t.v2_z = 16'($urandom_range(0, 15));
        end
        return t;
    endfunction

    task automatic make_triangle(output tun_pkg::triangle_t t,
                                 input int a, b, c, d, e, f, g, h, k);
        t.v0_x = tun_pkg::COORD_W'(a);
        t.v0_y = tun_pkg::COORD_W'(b);
        t.v0_z = tun_pkg::COORD_W'(c);
        t.v1_x = tun_pkg::COORD_W'(d);
        t.v1_y = tun_pkg::COORD_W'(e);
        t.v1_z = tun_pkg::COORD_W'(f);
        t.v2_x = tun_pkg::COORD_W'(g);
        t.v2_y = tun_pkg::COORD_W'(h);
        t.v2_z = tun_pkg::COORD_W'(k);
    endtask

    task automatic test_directed();
        tun_pkg::triangle_t t;
        make_triangle(t, 0, 0, 0, 256, 0, 0, 0, 256, 0); send_triangle(t);
        make_triangle(t, 0, 0, 0, 0, 256, 0, 256, 0, 0); send_triangle(t);
        make_triangle(t, 0, 0, 0, 0, 0, 256, 256, 0, 0); send_triangle(t);
        make_triangle(t, 0, 0, 0, 0, 0, 0, 0, 0, 0); send_triangle(t);
        make_triangle(t, 5, 5, 5, 10, 10, 10, 20, 20, 20); send_triangle(t);
        make_triangle(t, 7, 7, 7, 7, 7, 7, 100, -3, 9); send_triangle(t);
        make_triangle(t, -32768, -32768, -32768, 32767, 32767, 32767,
                      -32768, 32767, -32768); send_triangle(t);
        make_triangle(t, 32767, -32768, 0, -32768, 32767, 32767,
                      32767, 32767, -32768); send_triangle(t);
        make_triangle(t, -32768, 0, 0, 32767, 0, 0, 32767, 32767, 0); send_triangle(t);
        make_triangle(t, 0, 0, 0, 1, 0, 0, 0, 1, 0); send_triangle(t);
        make_triangle(t, 0, 0, 0, 1, 1, 0, 0, 1, 1); send_triangle(t);
        make_triangle(t, 0, 0, 0, -1, 0, 0, 0, 1, 0); send_triangle(t);
        make_triangle(t, 1, 2, 3, 4, 6, 8, 5, -7, 11); send_triangle(t);
        make_triangle(t, 0, 0, 0, 3, 0, 0, 0, 4, 0); send_triangle(t);
        make_triangle(t, 0, 0, 0, 1, 0, 0, 0, 1, 1); send_triangle(t);
        make_triangle(t, -1, -1, -1, -1, -1, -1, -1, -1, -1); send_triangle(t);
    endtask

    task automatic test_random(int count);
        repeat (count)
            send_triangle(random_triangle());
    endtask

    task automatic test_drain_pause();
        triangle_valid <= 1'b0;
        while (normal_queue.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        error_count = 0;
        result_count = 0;
        stall_left = 0;
        idle_enable = 1'b1;
        rst_n = 1'b0;
        triangle_valid = 1'b0;
        triangle = '0;
        normal_ready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(150);
        test_drain_pause();
        test_random(150);
        idle_enable = 1'b0;
        test_random(100);
        test_drain_pause();
        repeat (80) @(posedge clk);
        if (error_count == 0)
            $display("triangle_unit_normal_tb passed");
        else
            $display("triangle_unit_normal_tb failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("triangle_unit_normal_tb failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/tun_pkg.sv
sv/tun_sqrt.sv
sv/tun_div.sv
sv/triangle_unit_normal.sv
sim/triangle_unit_normal_tb.sv
